// ===== src/ddoih_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddoih_pkg
// shared types, codes and constants of the odometry / imu heading block
// ----------------------------------------------------------------------------
package ddoih_pkg;

   localparam int PERIOD_MS    = 10;
   localparam int CSR_WIDTH    = 24;
   localparam int DIV_STEPS    = 32;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   // sine polynomial coefficients, q16
   localparam logic [16:0] SIN_A = 17'd102943;
   localparam logic [16:0] SIN_B = 17'd42047;
   localparam logic [16:0] SIN_C = 17'd4640;

   typedef enum logic [1:0] {
      OP_SAMPLE    = 2'd0,
      OP_NOT_READY = 2'd1,
      OP_FAULT     = 2'd2,
      OP_SET_POSE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_ACTIVE = 2'd1,
      MODE_ERROR  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CSR_LEFT_MM_PER_TICK  = 2'd0,
      CSR_RIGHT_MM_PER_TICK = 2'd1,
      CSR_LEFT_REVERSE      = 2'd2,
      CSR_RIGHT_REVERSE     = 2'd3
   } csr_index_type;

   typedef struct packed {
      opcode_type         opcode;
      logic        [31:0] left_ticks;
      logic        [31:0] right_ticks;
      logic signed [15:0] imu_yaw;
      logic signed [15:0] imu_rate;
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic signed [15:0] pose_yaw;
   } ddoih_req_type;

   typedef struct packed {
      logic signed [31:0] x_mm;
      logic signed [31:0] y_mm;
      logic signed [31:0] forward_speed;
      logic signed [15:0] heading;
      logic signed [15:0] turn_rate;
      mode_type           mode;
   } ddoih_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ELAPSE, ST_POSE, ST_FAULT, ST_REBASE, ST_PREP,
      ST_TZ, ST_TC, ST_TR1, ST_TR2, ST_TV,
      ST_WL, ST_WR, ST_SUM, ST_MAG,
      ST_PLO, ST_PHI, ST_PINC, ST_PADD,
      ST_SPN, ST_SPC, ST_DIV, ST_COMMIT, ST_OUT
   } ctrl_state_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_LOAD, DP_ELAPSE, DP_POSE, DP_FAULT, DP_REBASE, DP_PREP,
      DP_TRIG_Z, DP_TRIG_C, DP_TRIG_R1, DP_TRIG_R2, DP_TRIG_V,
      DP_WHEEL_L, DP_WHEEL_R, DP_SUM, DP_MAG,
      DP_POS_LO, DP_POS_HI, DP_POS_INC, DP_POS_ADD,
      DP_SPD_N, DP_SPD_CHK, DP_DIV, DP_COMMIT, DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      sel;   // 0: cosine / x, 1: sine / y
   } dp_cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       need_rebase;
   } dp_status_type;

endpackage

// ===== src/ddoih_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddoih_ctrl
// sequencer: steps the datapath through one request and owns the handshakes
// ----------------------------------------------------------------------------
module ddoih_ctrl
   import ddoih_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type          state_ff, state_in;
   logic                    sel_ff, sel_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_load;

   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      sel_in     = sel_ff;
      div_cnt_in = div_cnt_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_ELAPSE;
         ST_ELAPSE: begin
            unique case (status.opcode)
               OP_SET_POSE:  state_in = ST_POSE;
               OP_FAULT:     state_in = ST_FAULT;
               OP_NOT_READY: state_in = ST_OUT;
               OP_SAMPLE:    state_in = status.need_rebase ? ST_REBASE : ST_PREP;
               default:      state_in = ST_OUT;
            endcase
         end
         ST_POSE, ST_FAULT, ST_REBASE: state_in = ST_OUT;
         ST_PREP: begin
            sel_in   = 1'b0;
            state_in = ST_TZ;
         end
         ST_TZ:  state_in = ST_TC;
         ST_TC:  state_in = ST_TR1;
         ST_TR1: state_in = ST_TR2;
         ST_TR2: state_in = ST_TV;
         ST_TV: begin
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_TZ;
            end else begin
               state_in = ST_WL;
            end
         end
         ST_WL:  state_in = ST_WR;
         ST_WR:  state_in = ST_SUM;
         ST_SUM: state_in = ST_MAG;
         ST_MAG: begin
            sel_in   = 1'b0;
            state_in = ST_PLO;
         end
         ST_PLO:  state_in = ST_PHI;
         ST_PHI:  state_in = ST_PINC;
         ST_PINC: state_in = ST_PADD;
         ST_PADD: begin
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_PLO;
            end else begin
               state_in = ST_SPN;
            end
         end
         ST_SPN: state_in = ST_SPC;
         ST_SPC: begin
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) state_in = ST_COMMIT;
         end
         ST_COMMIT: state_in = ST_OUT;
         ST_OUT:    if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.sel   = sel_ff;
      cmd.op    = DP_NOP;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.op = DP_LOAD;
         end
         ST_ELAPSE: cmd.op = DP_ELAPSE;
         ST_POSE:   cmd.op = DP_POSE;
         ST_FAULT:  cmd.op = DP_FAULT;
         ST_REBASE: cmd.op = DP_REBASE;
         ST_PREP:   cmd.op = DP_PREP;
         ST_TZ:     cmd.op = DP_TRIG_Z;
         ST_TC:     cmd.op = DP_TRIG_C;
         ST_TR1:    cmd.op = DP_TRIG_R1;
         ST_TR2:    cmd.op = DP_TRIG_R2;
         ST_TV:     cmd.op = DP_TRIG_V;
         ST_WL:     cmd.op = DP_WHEEL_L;
         ST_WR:     cmd.op = DP_WHEEL_R;
         ST_SUM:    cmd.op = DP_SUM;
         ST_MAG:    cmd.op = DP_MAG;
         ST_PLO:    cmd.op = DP_POS_LO;
         ST_PHI:    cmd.op = DP_POS_HI;
         ST_PINC:   cmd.op = DP_POS_INC;
         ST_PADD:   cmd.op = DP_POS_ADD;
         ST_SPN:    cmd.op = DP_SPD_N;
         ST_SPC:    cmd.op = DP_SPD_CHK;
         ST_DIV:    cmd.op = DP_DIV;
         ST_COMMIT: cmd.op = DP_COMMIT;
         ST_OUT:    if (out_load) cmd.op = DP_OUT;
         default:   cmd.op = DP_NOP;
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("response raised outside output state");

   a_prep_after_elapse: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PREP |-> $past(state_ff) == ST_ELAPSE)
      else $error("integration entered without elapsed update");

   a_commit_after_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |-> $past(state_ff) == ST_DIV && $past(div_cnt_ff) == DIV_LAST)
      else $error("commit before divider finished");

endmodule

// ===== src/ddoih_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddoih_datapath
// pose state, shared multiplier, sine polynomial and speed divider
// ----------------------------------------------------------------------------
module ddoih_datapath
   import ddoih_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ddoih_req_type        req_data,
   output ddoih_rsp_type        rsp_data,
   input  logic                 csr_we,
   input  csr_index_type        csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata,
   input  dp_cmd_type           cmd,
   output dp_status_type        status
);

   localparam logic signed [59:0] POS_HI = 60'sh7FFF_FFFF_FFFF;
   localparam logic signed [59:0] POS_LO = -POS_HI - 60'sd1;

   function automatic logic [16:0] quarter_z(input logic [31:0] a);
      logic [30:0] f;
      f = {1'b0, a[29:0]};
      if (a[30]) f = 31'h4000_0000 - f;
      return f[30:14];
   endfunction

   function automatic logic [31:0] mm_out(input logic signed [47:0] p);
      logic [47:0] m;
      logic [48:0] s;
      logic [32:0] r;
      m = p[47] ? 48'(-p) : 48'(p);
      s = {1'b0, m} + 49'h8000;
      r = s[48:16];
      if (!p[47]) return (r > 33'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
      return 32'(-r[31:0]);
   endfunction

   // configuration
   logic [23:0] kl_ff, kr_ff;
   logic        revl_ff, revr_ff;

   // architectural state
   ddoih_req_type      req_ff;
   logic               need_rebase_ff;
   logic [31:0]        last_l_ff, last_r_ff;
   logic [15:0]        last_heading_ff, yaw_offset_ff, elapsed_ff, heading_ff;
   logic signed [47:0] pos_ff [2];
   logic [31:0]        speed_ff;
   logic [15:0]        rate_ff;
   mode_type           mode_ff;

   // work registers
   logic [15:0]        yaw_new_ff;
   logic [16:0]        z_ff [2];
   logic               qneg_ff [2];
   logic [16:0]        trig_ff [2];
   logic [16:0]        z2_ff;
   logic [55:0]        prod_ff;
   logic [31:0]        magl_ff, magr_ff;
   logic               negl_ff, negr_ff;
   logic [55:0]        tl_ff;
   logic [56:0]        mag_ff;
   logic               sneg_ff;
   logic [55:0]        plo_ff;
   logic signed [58:0] inc_ff;
   logic               ovf_ff;
   logic [49:0]        num_ff;
   logic [25:0]        ms_ff, rem_ff;
   logic [31:0]        quo_ff;
   logic               dsat_ff;
   ddoih_rsp_type      rsp_ff;

   // combinational
   logic [31:0]        mul_a;
   logic [23:0]        mul_b;
   logic [15:0]        yaw_new, dy;
   logic [16:0]        mid2;
   logic [31:0]        a_sin, a_cos, dl, dr;
   logic [16:0]        r1, r2, tv;
   logic signed [57:0] sum;
   logic [88:0]        full;
   logic [57:0]        incv;
   logic               ineg;
   logic signed [59:0] psum;
   logic signed [47:0] pnew;
   logic               povf;
   logic [25:0]        ms, ms1;
   logic [69:0]        m70, nfull;
   logic [26:0]        dt;
   logic               dge;
   logic [31:0]        spd;

   always_comb begin
      yaw_new = 16'(req_ff.imu_yaw) + yaw_offset_ff;
      dy      = yaw_new - last_heading_ff;
      mid2    = {heading_ff, 1'b0} + {dy[15], dy};
      a_sin   = {mid2, 15'b0};
      a_cos   = a_sin + 32'h4000_0000;
      dl      = req_ff.left_ticks - last_l_ff;
      dr      = req_ff.right_ticks - last_r_ff;

      r1 = SIN_B - prod_ff[32:16];
      r2 = SIN_A - prod_ff[32:16];
      tv = (prod_ff[33:16] > 18'd65536) ? 17'd65536 : prod_ff[32:16];

      sum = (negl_ff ? -$signed({2'b0, tl_ff}) : $signed({2'b0, tl_ff}))
          + (negr_ff ? -$signed({2'b0, prod_ff}) : $signed({2'b0, prod_ff}));

      full = {1'b0, prod_ff, 32'b0} + {33'b0, plo_ff} + 89'h1_0000;
      incv = full[74:17];
      ineg = sneg_ff ^ (qneg_ff[cmd.sel] && (trig_ff[cmd.sel] != 17'd0));

      psum = {{12{pos_ff[cmd.sel][47]}}, pos_ff[cmd.sel]} + {inc_ff[58], inc_ff};
      povf = 1'b0;
      if (psum > POS_HI) begin
         pnew = POS_HI[47:0];
         povf = 1'b1;
      end else if (psum < POS_LO) begin
         pnew = POS_LO[47:0];
         povf = 1'b1;
      end else begin
         pnew = psum[47:0];
      end

      ms    = 26'(elapsed_ff) * 26'(PERIOD_MS);
      ms1   = (ms == 26'd0) ? 26'd1 : ms;
      m70   = 70'(mag_ff);
      // 2000 * mag plus half the divisor, divisor scaled by 2^18 removed
      nfull = (m70 << 11) - (m70 << 5) - (m70 << 4) + (70'(ms1) << 17);

      dt  = {rem_ff, quo_ff[31]};
      dge = dt >= {1'b0, ms_ff};

      if (sneg_ff) begin
         spd = (dsat_ff || quo_ff > 32'h8000_0000) ? 32'h8000_0000 : 32'(-quo_ff);
      end else begin
         spd = (dsat_ff || quo_ff[31]) ? 32'h7FFF_FFFF : quo_ff;
      end

      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         DP_TRIG_Z: begin
            mul_a = 32'(z_ff[cmd.sel]);
            mul_b = 24'(z_ff[cmd.sel]);
         end
         DP_TRIG_C: begin
            mul_a = 32'(prod_ff[32:16]);
            mul_b = 24'(SIN_C);
         end
         DP_TRIG_R1: begin
            mul_a = 32'(z2_ff);
            mul_b = 24'(r1);
         end
         DP_TRIG_R2: begin
            mul_a = 32'(z_ff[cmd.sel]);
            mul_b = 24'(r2);
         end
         DP_WHEEL_L: begin
            mul_a = magl_ff;
            mul_b = kl_ff;
         end
         DP_WHEEL_R: begin
            mul_a = magr_ff;
            mul_b = kr_ff;
         end
         DP_POS_LO: begin
            mul_a = mag_ff[31:0];
            mul_b = 24'(trig_ff[cmd.sel]);
         end
         DP_POS_HI: begin
            mul_a = 32'(mag_ff[56:32]);
            mul_b = 24'(trig_ff[cmd.sel]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kl_ff   <= 24'd65536;
         kr_ff   <= 24'd65536;
         revl_ff <= 1'b0;
         revr_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LEFT_MM_PER_TICK:  kl_ff   <= csr_wdata;
            CSR_RIGHT_MM_PER_TICK: kr_ff   <= csr_wdata;
            CSR_LEFT_REVERSE:      revl_ff <= csr_wdata[0];
            CSR_RIGHT_REVERSE:     revr_ff <= csr_wdata[0];
            default:               kl_ff   <= kl_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         need_rebase_ff  <= 1'b1;
         last_l_ff       <= '0;
         last_r_ff       <= '0;
         last_heading_ff <= '0;
         yaw_offset_ff   <= '0;
         elapsed_ff      <= '0;
         pos_ff[0]       <= '0;
         pos_ff[1]       <= '0;
         heading_ff      <= '0;
         speed_ff        <= '0;
         rate_ff         <= '0;
         mode_ff         <= MODE_IDLE;
      end else begin
         case (cmd.op)
            DP_ELAPSE: begin
               if (req_ff.opcode != OP_SET_POSE && !need_rebase_ff
                   && elapsed_ff != 16'hFFFF)
                  elapsed_ff <= elapsed_ff + 16'd1;
            end
            DP_POSE: begin
               pos_ff[0]      <= {req_ff.pose_x, 16'b0};
               pos_ff[1]      <= {req_ff.pose_y, 16'b0};
               heading_ff     <= req_ff.pose_yaw;
               speed_ff       <= '0;
               rate_ff        <= '0;
               need_rebase_ff <= 1'b1;
            end
            DP_FAULT: begin
               speed_ff <= '0;
               rate_ff  <= '0;
               mode_ff  <= MODE_ERROR;
            end
            DP_REBASE: begin
               yaw_offset_ff   <= heading_ff - 16'(req_ff.imu_yaw);
               last_heading_ff <= heading_ff;
               last_l_ff       <= req_ff.left_ticks;
               last_r_ff       <= req_ff.right_ticks;
               elapsed_ff      <= '0;
               need_rebase_ff  <= 1'b0;
               speed_ff        <= '0;
               rate_ff         <= '0;
               mode_ff         <= MODE_ACTIVE;
            end
            DP_POS_ADD: pos_ff[cmd.sel] <= pnew;
            DP_COMMIT: begin
               heading_ff      <= yaw_new_ff;
               last_heading_ff <= yaw_new_ff;
               last_l_ff       <= req_ff.left_ticks;
               last_r_ff       <= req_ff.right_ticks;
               elapsed_ff      <= '0;
               if (ovf_ff) begin
                  speed_ff <= '0;
                  rate_ff  <= '0;
                  mode_ff  <= MODE_ERROR;
               end else begin
                  speed_ff <= spd;
                  rate_ff  <= req_ff.imu_rate;
                  mode_ff  <= MODE_ACTIVE;
               end
            end
            default: need_rebase_ff <= need_rebase_ff;
         endcase
      end
   end

   // work registers, no reset
   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_LOAD: req_ff <= req_data;
         DP_PREP: begin
            yaw_new_ff <= yaw_new;
            z_ff[0]    <= quarter_z(a_cos);
            z_ff[1]    <= quarter_z(a_sin);
            qneg_ff[0] <= a_cos[31];
            qneg_ff[1] <= a_sin[31];
            negl_ff    <= dl[31] ^ revl_ff;
            negr_ff    <= dr[31] ^ revr_ff;
            magl_ff    <= dl[31] ? 32'(-dl) : dl;
            magr_ff    <= dr[31] ? 32'(-dr) : dr;
         end
         DP_TRIG_C:  z2_ff <= prod_ff[32:16];
         DP_TRIG_V:  trig_ff[cmd.sel] <= tv;
         DP_WHEEL_R: tl_ff <= prod_ff;
         DP_SUM: begin
            sneg_ff <= sum[57];
            mag_ff  <= sum[57] ? 57'(-sum) : 57'(sum);
         end
         DP_POS_HI:  plo_ff <= prod_ff;
         DP_POS_INC: inc_ff <= ineg ? -$signed({1'b0, incv}) : $signed({1'b0, incv});
         DP_SPD_N: begin
            num_ff <= nfull[67:18];
            ms_ff  <= ms1;
         end
         DP_SPD_CHK: begin
            dsat_ff <= {8'b0, num_ff[49:32]} >= ms_ff;
            rem_ff  <= {8'b0, num_ff[49:32]};
            quo_ff  <= num_ff[31:0];
         end
         DP_DIV: begin
            rem_ff <= dge ? 26'(dt - {1'b0, ms_ff}) : dt[25:0];
            quo_ff <= {quo_ff[30:0], dge};
         end
         DP_OUT: begin
            rsp_ff.x_mm          <= mm_out(pos_ff[0]);
            rsp_ff.y_mm          <= mm_out(pos_ff[1]);
            rsp_ff.forward_speed <= speed_ff;
            rsp_ff.heading       <= heading_ff;
            rsp_ff.turn_rate     <= rate_ff;
            rsp_ff.mode          <= mode_ff;
         end
         default: z2_ff <= z2_ff;
      endcase
   end

   // overflow flag of one integration
   always_ff @(posedge clock) begin
      if (cmd.op == DP_PREP) ovf_ff <= 1'b0;
      else if (cmd.op == DP_POS_ADD && povf) ovf_ff <= 1'b1;
   end

   assign rsp_data           = rsp_ff;
   assign status.opcode      = req_ff.opcode;
   assign status.need_rebase = need_rebase_ff;

endmodule

// ===== src/diff_drive_odometry_imu_heading_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_odometry_imu_heading_top
// differential drive odometry with imu heading, midpoint integration
// ----------------------------------------------------------------------------
//  channel  ports                               direction  payload
//  req      req_valid / req_stall / req_data    in         ddoih_req_type
//  rsp      rsp_valid / rsp_stall / rsp_data    out        ddoih_rsp_type
//  csr      csr_we / csr_index / csr_wdata      in         24-bit register write
//
//  a request is taken only while the sequencer is idle; set pose, fault, not
//  ready and rebase samples skip the integration, an integrating sample runs
//  two 5-step sine polynomials, 4 wheel steps and 8 position steps through one
//  shared 32x24 multiplier, then a 32-step restoring divider for speed
//  synchronous reset restores the default register values and pose state
//  the result register lets the next request enter while a response stalls
// ----------------------------------------------------------------------------
module diff_drive_odometry_imu_heading_top
   import ddoih_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ddoih_req_type        req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ddoih_rsp_type        rsp_data,
   input  logic                 csr_we,
   input  csr_index_type        csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata
);

   // sequencer to datapath commands and datapath status back
   dp_cmd_type    cmd;
   dp_status_type status;

   // controller: request handshake, step sequence, response register valid
   ddoih_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: configuration, pose state, arithmetic and response payload
   ddoih_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== verif/diff_drive_odometry_imu_heading_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_odometry_imu_heading_top_tb
// self-checking bench: a directed table followed by random sample streams
// (good sequences, skipped samples, faults, pose sets) under several wheel
// scale settings; each response is compared with a typed row or a bit-exact
// odometry model while requests arrive in bursts and the response side stalls
// ----------------------------------------------------------------------------
module diff_drive_odometry_imu_heading_top_tb;
   import ddoih_pkg::*;

   localparam int           RANDOM_ITEMS = 750;
   localparam int           CYCLE_LIMIT  = 800000;
   localparam int           DRAIN_CYCLES = 100;
   localparam longint       POS_LIM      = 64'sd1 <<< 47;
   localparam longint       TRAVEL_LIM   = 64'sd1 <<< 61;

   typedef struct {
      ddoih_req_type req;
      bit            typed;
      ddoih_rsp_type rsp;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   ddoih_req_type        req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   ddoih_rsp_type        rsp_data;
   logic                 csr_we = 1'b0;
   csr_index_type        csr_index = CSR_LEFT_MM_PER_TICK;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   // odometry model state
   logic [23:0]   od_k_left, od_k_right;
   logic          od_rev_left, od_rev_right;
   logic          od_need_rebase;
   logic [31:0]   od_last_left, od_last_right;
   logic [15:0]   od_last_heading, od_yaw_offset, od_elapsed, od_heading;
   longint        od_pos_x, od_pos_y, od_speed;
   logic [15:0]   od_rate;
   mode_type      od_mode;

   ddoih_rsp_type pose_q[$];
   dir_row_type   dir_rows[$];
   int            error_count = 0;
   longint        cycle_count = 0;

   // stimulus trackers for well-formed sample streams
   logic [31:0]   gen_left, gen_right;
   logic [15:0]   gen_yaw;

   diff_drive_odometry_imu_heading_top dut (.*);

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("diff_drive_odometry_imu_heading_top_tb: done, errors");
         $finish;
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   // ---------------------------------------------------------------- model

   function automatic longint sine_q16(input logic [31:0] a);
      longint unsigned f, z, z2, r, v;
      f = a[29:0];
      if (a[30]) f = (64'd1 << 30) - f;
      z  = f >> 14;
      z2 = (z * z) >> 16;
      r  = SIN_B - ((z2 * SIN_C) >> 16);
      r  = SIN_A - ((z2 * r) >> 16);
      v  = (z * r) >> 16;
      if (v > 65536) v = 65536;
      return a[31] ? -longint'(v) : longint'(v);
   endfunction

   function automatic longint wheel_travel(input logic [31:0] now, input logic [31:0] last,
                                           input logic [23:0] k, input logic rev,
                                           inout bit ovf);
      logic [31:0]     d;
      logic            neg;
      longint unsigned mag;
      d   = now - last;
      neg = d[31];
      mag = neg ? longint'(32'(-d)) : longint'(d);
      if (neg && mag == 0) mag = 64'd1 << 31;
      neg ^= rev;
      if (k == 0 || mag == 0) return 0;
      if (mag > TRAVEL_LIM / k) begin
         mag = TRAVEL_LIM;
         ovf = 1'b1;
      end else begin
         mag = mag * k;
      end
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint pos_increment(input longint sum, input longint trig);
      longint unsigned mag, c, q, v;
      mag = sum < 0 ? -sum : sum;
      c   = trig < 0 ? -trig : trig;
      q   = ((mag & 64'hFFFF) * c + 64'h10000) >> 16;
      v   = ((mag >> 16) * c + q) >> 1;
      return ((sum < 0) != (trig < 0)) ? -longint'(v) : longint'(v);
   endfunction

   function automatic longint clamp_pos(input longint p, inout bit ovf);
      if (p > POS_LIM - 1) begin ovf = 1'b1; return POS_LIM - 1; end
      if (p < -POS_LIM) begin ovf = 1'b1; return -POS_LIM; end
      return p;
   endfunction

   function automatic longint speed_of(input longint sum);
      longint unsigned mag, ms, den, q, r, tot;
      mag = sum < 0 ? -sum : sum;
      ms  = od_elapsed * PERIOD_MS;
      if (ms == 0) ms = 1;
      den = ms << 17;
      q   = mag / den;
      r   = mag % den;
      if (q > (64'd1 << 22)) tot = 64'd1 << 32;
      else tot = q * 1000 + (2 * r * 1000 + den) / (2 * den);
      if (sum < 0) return tot > 64'h80000000 ? -64'sh80000000 : -longint'(tot);
      return tot > 64'h7FFFFFFF ? 64'sh7FFFFFFF : longint'(tot);
   endfunction

   function automatic logic [31:0] mm_round(input longint p);
      longint unsigned r;
      if (p >= 0) begin
         r = (p + 32768) >> 16;
         return r > 64'h7FFFFFFF ? 32'h7FFFFFFF : r[31:0];
      end
      r = (-p + 32768) >> 16;
      if (r > 64'h80000000) r = 64'h80000000;
      return -r[31:0];
   endfunction

   function automatic void odo_reset();
      od_k_left = 24'd65536;  od_k_right = 24'd65536;
      od_rev_left = 0;        od_rev_right = 0;
      od_need_rebase = 1;
      od_last_left = 0;       od_last_right = 0;
      od_last_heading = 0;    od_yaw_offset = 0;
      od_elapsed = 0;         od_heading = 0;
      od_pos_x = 0;           od_pos_y = 0;
      od_speed = 0;           od_rate = 0;
      od_mode = MODE_IDLE;
   endfunction

   function automatic void odo_config(input csr_index_type idx, input logic [23:0] v);
      case (idx)
         CSR_LEFT_MM_PER_TICK:  od_k_left = v;
         CSR_RIGHT_MM_PER_TICK: od_k_right = v;
         CSR_LEFT_REVERSE:      od_rev_left = v[0];
         CSR_RIGHT_REVERSE:     od_rev_right = v[0];
      endcase
   endfunction

   // advance the model by one request and return the pose it reports
   function automatic ddoih_rsp_type odo_step(input ddoih_req_type q);
      ddoih_rsp_type o;
      bit            ovf;
      logic [15:0]   yaw_new;
      logic [16:0]   dy, mid2;
      logic [31:0]   a32;
      longint        sum;
      ovf = 0;
      if (q.opcode == OP_SET_POSE) begin
         od_pos_x = longint'(q.pose_x) <<< 16;
         od_pos_y = longint'(q.pose_y) <<< 16;
         od_heading = q.pose_yaw;
         od_speed = 0;
         od_rate = 0;
         od_need_rebase = 1;
      end else begin
         if (!od_need_rebase && od_elapsed != 16'hFFFF) od_elapsed++;
         if (q.opcode == OP_FAULT) begin
            od_speed = 0; od_rate = 0; od_mode = MODE_ERROR;
         end else if (q.opcode == OP_SAMPLE && od_need_rebase) begin
            // rebase: heading carries on from the current pose
            od_yaw_offset = od_heading - q.imu_yaw;
            od_last_heading = od_heading;
            od_last_left = q.left_ticks;
            od_last_right = q.right_ticks;
            od_elapsed = 0;
            od_need_rebase = 0;
            od_speed = 0; od_rate = 0; od_mode = MODE_ACTIVE;
         end else if (q.opcode == OP_SAMPLE) begin
            yaw_new = q.imu_yaw + od_yaw_offset;
            dy = {1'b0, 16'(yaw_new - od_last_heading)};
            dy[16] = dy[15];
            mid2 = {od_heading, 1'b0} + dy;
            a32 = {mid2, 15'b0};
            sum = wheel_travel(q.left_ticks, od_last_left, od_k_left, od_rev_left, ovf)
                + wheel_travel(q.right_ticks, od_last_right, od_k_right, od_rev_right, ovf);
            od_pos_x = clamp_pos(od_pos_x + pos_increment(sum, sine_q16(a32 + 32'h40000000)),
                                 ovf);
            od_pos_y = clamp_pos(od_pos_y + pos_increment(sum, sine_q16(a32)), ovf);
            od_heading = yaw_new;
            od_last_heading = yaw_new;
            od_last_left = q.left_ticks;
            od_last_right = q.right_ticks;
            if (ovf) begin
               od_speed = 0; od_rate = 0; od_mode = MODE_ERROR;
            end else begin
               od_speed = speed_of(sum);
               od_rate = q.imu_rate;
               od_mode = MODE_ACTIVE;
            end
            od_elapsed = 0;
         end
      end
      o.x_mm = mm_round(od_pos_x);
      o.y_mm = mm_round(od_pos_y);
      o.forward_speed = od_speed[31:0];
      o.heading = od_heading;
      o.turn_rate = od_rate;
      o.mode = od_mode;
      return o;
   endfunction

   // ---------------------------------------------------------------- response side

   // stall pattern: runs of no stall, light and heavy stalling
   int stall_run = 0;
   int stall_kind = 0;
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_kind <= $urandom_range(0, 2);
         stall_run <= $urandom_range(5, 200);
         rsp_stall <= 1'b0;
      end else begin
         stall_run <= stall_run - 1;
         case (stall_kind)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 2);
            default: rsp_stall <= ($urandom_range(0, 9) < 8);
         endcase
      end
   end

   // compare every accepted response with the oldest predicted pose
   always @(posedge clock) begin
      ddoih_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pose_q.size() == 0) begin
            $display("unexpected response (cycle %0d)", cycle_count);
            error_count++;
         end else begin
            want = pose_q.pop_front();
            if (rsp_data.x_mm !== want.x_mm) report("x_mm", rsp_data.x_mm, want.x_mm);
            if (rsp_data.y_mm !== want.y_mm) report("y_mm", rsp_data.y_mm, want.y_mm);
            if (rsp_data.forward_speed !== want.forward_speed)
               report("forward_speed", rsp_data.forward_speed, want.forward_speed);
            if (rsp_data.heading !== want.heading)
               report("heading", rsp_data.heading, want.heading);
            if (rsp_data.turn_rate !== want.turn_rate)
               report("turn_rate", rsp_data.turn_rate, want.turn_rate);
            if (rsp_data.mode !== want.mode) report("mode", rsp_data.mode, want.mode);
         end
      end
   end

   // ---------------------------------------------------------------- request side

   int burst_left = 0;

   // hand one request over; a typed expectation replaces the model's answer
   task automatic send(input ddoih_req_type q, input bit typed, input ddoih_rsp_type fixed);
      ddoih_rsp_type p;
      int            gap;
      req_data <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      p = odo_step(q);
      pose_q.push_back(typed ? fixed : p);
      // bursts with random gaps between them
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      end else begin
         burst_left--;
         gap = 0;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      wait (pose_q.size() == 0);
      repeat (80) @(posedge clock);
   endtask

   // the caller drops the write enable after the last write of a group
   task automatic csr_write(input csr_index_type idx, input logic [23:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      odo_config(idx, v);
   endtask

   function automatic ddoih_req_type raw_req(input opcode_type op);
      ddoih_req_type q;
      logic [191:0]  bits;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      q = bits[$bits(ddoih_req_type)-1:0];
      q.opcode = op;
      return q;
   endfunction

   function automatic void add_row(input opcode_type op, input logic [31:0] lt,
                                   input logic [31:0] rt, input logic [15:0] yaw,
                                   input logic [15:0] rate, input logic [31:0] px,
                                   input logic [31:0] py, input logic [15:0] pyaw,
                                   input bit typed, input ddoih_rsp_type fixed);
      dir_row_type r;
      r.req = '{op, lt, rt, yaw, rate, px, py, pyaw};
      r.typed = typed;
      r.rsp = fixed;
      dir_rows.push_back(r);
   endfunction

   function automatic logic [31:0] tick_step(input logic [31:0] cnt);
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 16) return cnt + $urandom_range(0, 6000) - 3000;
      if (sel < 18) return $urandom;
      return cnt;
   endfunction

   // random request: mostly sample streams that track the counters and yaw
   function automatic ddoih_req_type random_req();
      ddoih_req_type q;
      int            sel;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
         q = raw_req(OP_SAMPLE);
         gen_left = tick_step(gen_left);
         gen_right = tick_step(gen_right);
         gen_yaw = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                 : 16'(gen_yaw + $urandom_range(0, 4000) - 2000);
         q.left_ticks = gen_left;
         q.right_ticks = gen_right;
         q.imu_yaw = gen_yaw;
      end else if (sel < 80) begin
         q = raw_req(OP_NOT_READY);
      end else if (sel < 87) begin
         q = raw_req(OP_FAULT);
      end else begin
         q = raw_req(OP_SET_POSE);
         // poses near the limits provoke position saturation
         case ($urandom_range(0, 3))
            0: begin
               q.pose_x = $urandom_range(0, 1) ? 32'h7FFFFF00 : 32'h80000100;
               q.pose_y = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            end
            1: begin
               q.pose_x = $urandom_range(0, 200000) - 100000;
               q.pose_y = $urandom_range(0, 200000) - 100000;
            end
            default: ;
         endcase
      end
      return q;
   endfunction

   // ---------------------------------------------------------------- main sequence

   initial begin
      ddoih_rsp_type z;
      logic [23:0]   k_left[4]  = '{24'd1, 24'd16777215, 24'd70000, 24'd0};
      logic [23:0]   k_right[4] = '{24'd16777215, 24'd1, 24'd33000, 24'd0};
      bit            rev_left[4]  = '{1'b1, 1'b0, 1'b1, 1'b0};
      bit            rev_right[4] = '{1'b0, 1'b1, 1'b1, 1'b0};
      int            n;

      odo_reset();
      gen_left = 0;
      gen_right = 0;
      gen_yaw = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      z = '0;
      // not ready straight after reset: idle zero pose
      add_row(OP_NOT_READY, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'h7FFF, 16'h8000,
              32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1, z);
      // first sample only rebases
      z.mode = MODE_ACTIVE;
      add_row(OP_SAMPLE, 0, 0, 0, 16'h1234, 0, 0, 0, 1, z);
      add_row(OP_SAMPLE, 100, 100, 0, 16'h7FFF, 0, 0, 0, 0, z);
      // counters going backwards through the wrap
      add_row(OP_SAMPLE, 32'hFFFFFFF0, 32'hFFFFFF00, 16'h0800, 16'h8000, 0, 0, 0, 0, z);
      add_row(OP_NOT_READY, 0, 0, 0, 0, 0, 0, 0, 0, z);
      add_row(OP_NOT_READY, 0, 0, 0, 0, 0, 0, 0, 0, z);
      add_row(OP_SAMPLE, 32'h00000010, 32'h00000100, 16'h1000, 16'h0001, 0, 0, 0, 0, z);
      add_row(OP_FAULT, 0, 0, 0, 0, 0, 0, 0, 0, z);
      // good sample leaves error mode
      add_row(OP_SAMPLE, 32'h00000400, 32'h00000200, 16'hF000, 16'hFFFF, 0, 0, 0, 0, z);
      // pose at the extremes keeps the mode
      z = '{32'h7FFFFFFF, 32'h80000000, 0, 0, 0, MODE_ACTIVE};
      add_row(OP_SET_POSE, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 16'h0000, 1, z);
      add_row(OP_SAMPLE, 32'hFFFFFFFF, 0, 16'h8000, 16'h4000, 0, 0, 0, 0, z);
      // huge forward move along +x saturates the position
      add_row(OP_SAMPLE, 32'h7FFFFFFE, 32'h7FFFFFFF, 16'h8000, 16'h4000, 0, 0, 0, 0, z);
      // backing off the limit is a good sample again
      add_row(OP_SAMPLE, 32'hFFFFFFFE, 32'h7FFFFFFF, 16'h8000, 16'h2000, 0, 0, 0, 0, z);
      z = '{0, 0, 0, 0, 0, MODE_ACTIVE};
      add_row(OP_SET_POSE, 5, 5, 5, 5, 0, 0, 0, 1, z);
      add_row(OP_SAMPLE, 0, 0, 16'h8000, 0, 0, 0, 0, 0, z);
      // half-turn heading step, the edge of the signed step
      add_row(OP_SAMPLE, 1000, 3000, 16'h0000, 16'h8000, 0, 0, 0, 0, z);
      add_row(OP_SAMPLE, 32'h80001000, 32'h80003000, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0, z);
      add_row(OP_SAMPLE, 32'h80001000, 32'h80003000, 16'h7FFF, 16'h0, 0, 0, 0, 0, z);
      foreach (dir_rows[i]) send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

      // random phases over several wheel settings
      n = 0;
      for (int ph = 0; ph < 5; ph++) begin
         wait_idle();
         if (ph < 4) begin
            csr_write(CSR_LEFT_MM_PER_TICK, k_left[ph]);
            csr_write(CSR_RIGHT_MM_PER_TICK, k_right[ph]);
            csr_write(CSR_LEFT_REVERSE, 24'(rev_left[ph]));
            csr_write(CSR_RIGHT_REVERSE, 24'(rev_right[ph]));
         end else begin
            csr_write(CSR_LEFT_MM_PER_TICK, 24'($urandom));
            csr_write(CSR_RIGHT_MM_PER_TICK, 24'($urandom));
            csr_write(CSR_LEFT_REVERSE, 24'($urandom));
            csr_write(CSR_RIGHT_REVERSE, 24'($urandom));
         end
         csr_we <= 1'b0;
         repeat (RANDOM_ITEMS / 5) begin
            send(random_req(), 0, '0);
            n++;
         end
      end

      req_valid <= 1'b0;
      wait (pose_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("diff_drive_odometry_imu_heading_top_tb: done, clean");
      else
         $display("diff_drive_odometry_imu_heading_top_tb: done, errors");
      $finish;
   end

endmodule
